// File: rtl/kmer_minimizer_sketch_macros.svh
// assertion macros for the checker file of kmer_minimizer_sketch
// no dependencies; included by the checker module
`ifndef KMER_MINIMIZER_SKETCH_MACROS_SVH
`define KMER_MINIMIZER_SKETCH_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define KMS_CHECK_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define KMS_CHECK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/kms_pkg.sv
// shared types and constants of the k-mer minimizer sketch
// no dependencies; imported by every module of the block
`default_nettype none

package kms_pkg;

    // fnv-1a 32-bit constants
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] HASH_ONES = 32'hFFFF_FFFF;

    // configuration port
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 6;
    localparam int KMER_LEN_W    = 6;
    localparam int WINDOW_SIZE_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd1;

    localparam logic [KMER_LEN_W-1:0]    KMER_LEN_RESET    = 6'd15;
    localparam logic [WINDOW_SIZE_W-1:0] WINDOW_SIZE_RESET = 5'd10;

    // front to back queue
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [7:0] base;
        logic       last;
        logic       new_kmer;
    } kms_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_INSERT,
        S_SCAN,
        S_FINISH
    } kms_state_t;

endpackage

`default_nettype wire

// File: rtl/kmer_minimizer_sketch.sv
// top level of the k-mer minimizer sketch: configuration registers,
// front end, queue and back end; depends on kms_pkg, kms_front, kms_queue, kms_back
//
// usage:
// - input channel (in_valid / in_stall, payload base and last) takes one
//   character per beat; last marks the final character of a sequence
// - output channel (out_valid / out_stall, payload minimizer_hash, hash_valid,
//   sequence_end) gives zero or one result beat per input beat, in order
// - configuration: cfg_write with cfg_index selects kmer_length (index 0) or
//   window_size (index 1); write only while no beat is in flight
// - a character that forms no k-mer passes from idle straight to the finish
//   state; one that forms a k-mer also runs the hash and insert states and,
//   once the window is full and wider than one, the scan state
// - the back end works on one character at a time; a character that forms a
//   k-mer holds it through the single-multiplier hash loop and the window scan
// - a two-beat queue lets the front accept while the back is busy; a stalled
//   result sits in the output register while the back moves on
// - reset clears the counters, sets the repeat and running minimum to all
//   ones and restores kmer_length 15 and window_size 10
`default_nettype none

module kmer_minimizer_sketch #(
    parameter int KMER_MAX   = 32,
    parameter int WINDOW_MAX = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write port
    input  wire logic                             cfg_write,
    input  wire logic [kms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kms_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       base,
    input  wire logic                             last,
    // output channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [31:0]                           minimizer_hash,
    output logic                                  hash_valid,
    output logic                                  sequence_end
);
    import kms_pkg::*;

    localparam int KCNT_W = $clog2(KMER_MAX + 1);
    localparam int WCNT_W = $clog2(WINDOW_MAX + 1);

    logic [KMER_LEN_W-1:0]    kmer_length_reg;
    logic [KMER_LEN_W-1:0]    kmer_length_next;
    logic [WINDOW_SIZE_W-1:0] window_size_reg;
    logic [WINDOW_SIZE_W-1:0] window_size_next;

    // clamped lengths seen by front and back
    logic [KCNT_W-1:0]        k_len;
    logic [WCNT_W-1:0]        w_len;

    logic                     push;
    kms_item_t                push_item;
    logic                     q_full;
    logic                     q_pop;
    logic                     q_valid;
    kms_item_t                q_item;

    // register writes
    always_comb
    begin
        kmer_length_next = kmer_length_reg;
        window_size_next = window_size_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_KMER_LENGTH: kmer_length_next = cfg_data[KMER_LEN_W-1:0];
                REG_WINDOW_SIZE: window_size_next = cfg_data[WINDOW_SIZE_W-1:0];
                default:         kmer_length_next = kmer_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= KMER_LEN_RESET;
            window_size_reg <= WINDOW_SIZE_RESET;
        end
        else
        begin
            kmer_length_reg <= kmer_length_next;
            window_size_reg <= window_size_next;
        end
    end

    // out-of-range lengths clamp to 1..max
    always_comb
    begin
        if (kmer_length_reg == '0)
        begin
            k_len = KCNT_W'(1);
        end
        else if (32'(kmer_length_reg) > KMER_MAX)
        begin
            k_len = KCNT_W'(KMER_MAX);
        end
        else
        begin
            k_len = KCNT_W'(kmer_length_reg);
        end

        if (window_size_reg == '0)
        begin
            w_len = WCNT_W'(1);
        end
        else if (32'(window_size_reg) > WINDOW_MAX)
        begin
            w_len = WCNT_W'(WINDOW_MAX);
        end
        else
        begin
            w_len = WCNT_W'(window_size_reg);
        end
    end

    kms_front #(
        .KMER_MAX (KMER_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .k_len     (k_len),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .base      (base),
        .last      (last),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    kms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .item      (q_item)
    );

    kms_back #(
        .KMER_MAX   (KMER_MAX),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .k_len          (k_len),
        .w_len          (w_len),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .minimizer_hash (minimizer_hash),
        .hash_valid     (hash_valid),
        .sequence_end   (sequence_end)
    );

endmodule

`default_nettype wire

// File: rtl/kms_front.sv
// front end: input handshake, character count and k-mer classification
// depends on kms_pkg
`default_nettype none

module kms_front #(
    parameter int KMER_MAX = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [$clog2(KMER_MAX+1)-1:0]     k_len,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        base,
    input  wire logic                              last,
    input  wire logic                              q_full,
    output logic                                   push,
    output kms_pkg::kms_item_t                     push_item
);
    import kms_pkg::*;

    localparam int KCNT_W = $clog2(KMER_MAX + 1);

    logic [KCNT_W-1:0] chars_reg;
    logic [KCNT_W-1:0] chars_next;
    logic [KCNT_W-1:0] chars_inc;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // saturating count of characters in the current sequence
    assign chars_inc = (chars_reg == KCNT_W'(KMER_MAX)) ? chars_reg : chars_reg + 1'b1;

    always_comb
    begin
        push_item.base     = base;
        push_item.last     = last;
        push_item.new_kmer = (chars_inc >= k_len);
    end

    always_comb
    begin
        chars_next = chars_reg;
        if (push)
        begin
            chars_next = last ? '0 : chars_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg <= '0;
        end
        else
        begin
            chars_reg <= chars_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/kms_queue.sv
// two-entry queue carrying classified beats from front to back
// depends on kms_pkg
`default_nettype none

module kms_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire kms_pkg::kms_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    valid,
    output kms_pkg::kms_item_t      item
);
    import kms_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    kms_item_t         entry_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(Q_DEPTH));
    assign valid   = (count_reg != '0);
    assign item    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/kms_back.sv
// back end: character history, iterative fnv-1a hash, window minimum scan,
// repeat suppression and output register; depends on kms_pkg
`default_nettype none

module kms_back #(
    parameter int KMER_MAX   = 32,
    parameter int WINDOW_MAX = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [$clog2(KMER_MAX+1)-1:0]     k_len,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0]   w_len,
    input  wire logic                              q_valid,
    input  wire kms_pkg::kms_item_t                q_item,
    output logic                                   q_pop,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [31:0]                            minimizer_hash,
    output logic                                   hash_valid,
    output logic                                   sequence_end
);
    import kms_pkg::*;

    localparam int KCNT_W = $clog2(KMER_MAX + 1);
    localparam int WCNT_W = $clog2(WINDOW_MAX + 1);
    localparam int KIDX_W = (KMER_MAX > 1) ? $clog2(KMER_MAX) : 1;
    localparam int WIDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    kms_state_t        state_reg;
    kms_state_t        state_next;

    // history and window shift lines, newest at index 0
    logic [7:0]        hist_reg [KMER_MAX];
    logic [31:0]       hwin_reg [WINDOW_MAX];
    logic              hist_shift;
    logic              win_shift;

    logic [KIDX_W-1:0] kidx_reg;
    logic [KIDX_W-1:0] kidx_next;
    logic [WIDX_W-1:0] widx_reg;
    logic [WIDX_W-1:0] widx_next;
    logic [31:0]       h_reg;
    logic [31:0]       h_next;
    logic [31:0]       min_reg;
    logic [31:0]       min_next;
    logic [31:0]       run_min_reg;
    logic [31:0]       run_min_next;
    logic [31:0]       prev_reg;
    logic [31:0]       prev_next;
    logic [WCNT_W-1:0] kmers_reg;
    logic [WCNT_W-1:0] kmers_next;
    logic [WCNT_W-1:0] kmers_inc;
    logic              last_reg;
    logic              last_next;
    logic              full_reg;
    logic              full_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [31:0]       out_hash_reg;
    logic [31:0]       out_hash_next;
    logic              out_hv_reg;
    logic              out_hv_next;
    logic              out_end_reg;
    logic              out_end_next;

    logic [31:0]       h_mix;
    logic [31:0]       h_mul;
    logic              slot_free;
    logic              win_emit;
    logic              part_emit;
    logic              emit;

    assign out_valid      = out_valid_reg;
    assign minimizer_hash = out_hash_reg;
    assign hash_valid     = out_hv_reg;
    assign sequence_end   = out_end_reg;

    // one fnv-1a step per cycle, oldest character first
    assign h_mix = h_reg ^ {24'd0, hist_reg[kidx_reg]};
    assign h_mul = h_mix * FNV_PRIME;

    assign kmers_inc = (kmers_reg == WCNT_W'(WINDOW_MAX)) ? kmers_reg : kmers_reg + 1'b1;
    assign slot_free = !out_valid_reg || !out_stall;

    // end-of-step decision
    assign win_emit  = full_reg && (min_reg != prev_reg);
    assign part_emit = last_reg && (kmers_reg != '0) && (kmers_reg < w_len);
    assign emit      = win_emit || last_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = q_item.new_kmer ? S_HASH : S_FINISH;
                end
            end
            S_HASH:
            begin
                if (kidx_reg == '0)
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                if ((kmers_inc >= w_len) && (w_len > WCNT_W'(1)))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (widx_reg == WIDX_W'(w_len - 1'b1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!emit || slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        hist_shift     = 1'b0;
        win_shift      = 1'b0;
        kidx_next      = kidx_reg;
        widx_next      = widx_reg;
        h_next         = h_reg;
        min_next       = min_reg;
        run_min_next   = run_min_reg;
        prev_next      = prev_reg;
        kmers_next     = kmers_reg;
        last_next      = last_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_hash_next  = out_hash_reg;
        out_hv_next    = out_hv_reg;
        out_end_next   = out_end_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    hist_shift = 1'b1;
                    last_next  = q_item.last;
                    full_next  = 1'b0;
                    h_next     = FNV_BASIS;
                    kidx_next  = KIDX_W'(k_len - 1'b1);
                end
            end
            S_HASH:
            begin
                h_next = h_mul;
                if (kidx_reg != '0)
                begin
                    kidx_next = kidx_reg - 1'b1;
                end
            end
            S_INSERT:
            begin
                win_shift  = 1'b1;
                kmers_next = kmers_inc;
                min_next   = h_reg;
                widx_next  = WIDX_W'(1);
                full_next  = (kmers_inc >= w_len);
                if (h_reg < run_min_reg)
                begin
                    run_min_next = h_reg;
                end
            end
            S_SCAN:
            begin
                widx_next = widx_reg + 1'b1;
                if (hwin_reg[widx_reg] < min_reg)
                begin
                    min_next = hwin_reg[widx_reg];
                end
            end
            S_FINISH:
            begin
                if (emit && slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_hv_next    = win_emit || part_emit;
                    out_end_next   = last_reg;
                    if (win_emit)
                    begin
                        out_hash_next = min_reg;
                        prev_next     = min_reg;
                    end
                    else if (part_emit)
                    begin
                        out_hash_next = run_min_reg;
                    end
                    else
                    begin
                        out_hash_next = '0;
                    end
                    // sequence end: back to a fresh sequence
                    if (last_reg)
                    begin
                        kmers_next   = '0;
                        prev_next    = HASH_ONES;
                        run_min_next = HASH_ONES;
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kmers_reg     <= '0;
            prev_reg      <= HASH_ONES;
            run_min_reg   <= HASH_ONES;
            last_reg      <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kmers_reg     <= kmers_next;
            prev_reg      <= prev_next;
            run_min_reg   <= run_min_next;
            last_reg      <= last_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kidx_reg     <= kidx_next;
        widx_reg     <= widx_next;
        h_reg        <= h_next;
        min_reg      <= min_next;
        out_hash_reg <= out_hash_next;
        out_hv_reg   <= out_hv_next;
        out_end_reg  <= out_end_next;
        if (hist_shift)
        begin
            hist_reg[0] <= q_item.base;
            for (int i = 1; i < KMER_MAX; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
        if (win_shift)
        begin
            hwin_reg[0] <= h_reg;
            for (int i = 1; i < WINDOW_MAX; i++)
            begin
                hwin_reg[i] <= hwin_reg[i-1];
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/kms_checker.sv
// port-level checks of the k-mer minimizer sketch, bound to the top level
// depends on kmer_minimizer_sketch_macros.svh
`default_nettype none
`include "kmer_minimizer_sketch_macros.svh"

module kms_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] minimizer_hash,
    input wire logic        hash_valid,
    input wire logic        sequence_end
);

    // a stalled result beat holds
    `KMS_CHECK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(minimizer_hash) && $stable(hash_valid) && $stable(sequence_end), "result beat changed while stalled")

    // an empty marker carries a zero hash
    `KMS_CHECK_NOW(a_empty_zero, clk, rst_n, out_valid && !hash_valid, minimizer_hash == 32'd0, "empty marker with nonzero hash")

    // only the sequence end can produce an empty marker
    `KMS_CHECK_NOW(a_empty_at_end, clk, rst_n, out_valid && !hash_valid, sequence_end, "empty marker before sequence end")

endmodule

bind kmer_minimizer_sketch kms_checker u_kms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .minimizer_hash (minimizer_hash),
    .hash_valid     (hash_valid),
    .sequence_end   (sequence_end)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of kmer_minimizer_sketch: random and directed character streams
// checked beat by beat against an in-bench minimizer predictor; depends on kms_pkg and kmer_minimizer_sketch

module tb;
    import kms_pkg::*;

    localparam int KMER_MAX      = 32;
    localparam int WINDOW_MAX    = 16;
    localparam int PHASE_CHARS   = 44;
    // a character that forms a k-mer holds the back end through the hash loop and window scan,
    // and up to three characters can be in flight (queue plus back end)
    localparam int SETTLE_CYCLES = 200;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;

    // idling patterns, in the order the run goes through them
    typedef enum int {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FULL
    } pace_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         drain;   // hold this beat back until every result is in
    } char_beat_t;

    typedef struct {
        logic [31:0] hash;
        logic        valid;
        logic        seq_end;
    } minimizer_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // block ports, all inputs known from time zero
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [7:0]            base      = 8'h00;
    logic                  last      = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [31:0]           minimizer_hash;
    logic                  hash_valid;
    logic                  sequence_end;

    kmer_minimizer_sketch dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .base           (base),
        .last           (last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .minimizer_hash (minimizer_hash),
        .hash_valid     (hash_valid),
        .sequence_end   (sequence_end)
    );

    // predictor state, mirrors the block after reset
    logic [7:0]  char_hist [KMER_MAX]   = '{default: '0};   // newest first
    logic [31:0] hash_hist [WINDOW_MAX] = '{default: '0};   // newest first
    int unsigned char_count    = 0;
    int unsigned kmer_count    = 0;
    logic [31:0] last_minimizer = HASH_ONES;
    logic [31:0] seq_minimum    = HASH_ONES;
    logic [5:0]  kmer_len_reg   = KMER_LEN_RESET;
    logic [4:0]  window_reg     = WINDOW_SIZE_RESET;

    // stimulus and scoreboard
    char_beat_t  char_queue [$];
    minimizer_t  minimizer_queue [$];
    int unsigned chars_queued = 0;
    int unsigned chars_sent   = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_go     = 1'b0;
    bit          hold_taken  = 1'b0;
    int unsigned hold_left   = 0;
    char_beat_t  next_char;
    minimizer_t  predicted;
    minimizer_t  oldest;

    // effective register values after clamping
    function automatic int unsigned eff_k();
        if (kmer_len_reg == 0) return 1;
        if (kmer_len_reg > KMER_MAX) return KMER_MAX;
        return 32'(kmer_len_reg);
    endfunction

    function automatic int unsigned eff_w();
        if (window_reg == 0) return 1;
        if (window_reg > WINDOW_MAX) return WINDOW_MAX;
        return 32'(window_reg);
    endfunction

    // advance the predictor by one character; returns 1 when a result beat follows
    function automatic bit minimize_char(input logic [7:0] c, input logic lst,
                                         output minimizer_t res);
        int unsigned k;
        int unsigned w;
        int unsigned i;
        logic [31:0] h;
        logic [31:0] m;
        logic [31:0] value;
        bit          got_kmer;
        bit          fire;
        bit          hv;
        k = eff_k();
        w = eff_w();
        got_kmer = 1'b0;
        fire     = 1'b0;
        hv       = 1'b0;
        value    = '0;

        for (i = KMER_MAX - 1; i > 0; i--)
            char_hist[i] = char_hist[i-1];
        char_hist[0] = c;
        if (char_count < KMER_MAX)
            char_count++;

        // fnv-1a over the last k characters, oldest first
        if (char_count >= k)
        begin
            h = FNV_BASIS;
            for (i = k; i > 0; i--)
            begin
                h = h ^ {24'd0, char_hist[i-1]};
                h = h * FNV_PRIME;
            end
            for (i = WINDOW_MAX - 1; i > 0; i--)
                hash_hist[i] = hash_hist[i-1];
            hash_hist[0] = h;
            if (kmer_count < WINDOW_MAX)
                kmer_count++;
            if (h < seq_minimum)
                seq_minimum = h;
            got_kmer = 1'b1;
        end

        // window minimum, suppressed when it repeats
        if (got_kmer && kmer_count >= w)
        begin
            m = hash_hist[0];
            for (i = 1; i < w; i++)
                if (hash_hist[i] < m)
                    m = hash_hist[i];
            if (m != last_minimizer)
            begin
                last_minimizer = m;
                fire  = 1'b1;
                hv    = 1'b1;
                value = m;
            end
        end

        // sequence end: short sequences report their overall minimum
        if (lst)
        begin
            if (kmer_count > 0 && kmer_count < w)
            begin
                hv    = 1'b1;
                value = seq_minimum;
            end
            fire = 1'b1;
            char_count     = 0;
            kmer_count     = 0;
            last_minimizer = HASH_ONES;
            seq_minimum    = HASH_ONES;
        end

        res.hash    = hv ? value : '0;
        res.valid   = hv;
        res.seq_end = lst;
        return fire;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    // driver: predicts each accepted beat, then offers the next one or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (minimize_char(base, last, predicted))
                    minimizer_queue = {minimizer_queue, predicted};
                chars_sent++;
            end
            // payload only moves when nothing is waiting on the channel
            if (!in_valid || !in_stall)
            begin
                if (char_queue.size() != 0
                    && !(char_queue[0].drain && minimizer_queue.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    next_char = char_queue.pop_front();
                    in_valid <= 1'b1;
                    base     <= next_char.ch;
                    last     <= next_char.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall: one long hold-off on request, random stalls otherwise
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (hold_go && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: every result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (minimizer_queue.size() == 0)
                report_mismatch("result beat with none expected", minimizer_hash, '0);
            else
            begin
                oldest = minimizer_queue.pop_front();
                if (minimizer_hash !== oldest.hash)
                    report_mismatch("minimizer_hash", minimizer_hash, oldest.hash);
                if (hash_valid !== oldest.valid)
                    report_mismatch("hash_valid", {31'd0, hash_valid}, {31'd0, oldest.valid});
                if (sequence_end !== oldest.seq_end)
                    report_mismatch("sequence_end", {31'd0, sequence_end},
                                    {31'd0, oldest.seq_end});
            end
        end
    end

    // watchdog on cycles with no handshake and no register write
    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || cfg_write)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_char(input logic [7:0] c, input logic lst, input bit drain);
        char_beat_t b;
        b.ch    = c;
        b.last  = lst;
        b.drain = drain;
        char_queue = {char_queue, b};
        chars_queued++;
    endtask

    // every queued beat accepted, every result in, then let the back end settle
    task automatic wait_drained();
        while (chars_sent != chars_queued || minimizer_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] val);
        if (idx == REG_KMER_LENGTH)
            kmer_len_reg = val;
        else
            window_reg = val[4:0];
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_pace(input pace_t pace);
        case (pace)
            PACE_SLOW_SINK:
            begin
                send_idle_pct = 30;
                recv_idle_pct = 52;
            end
            PACE_SLOW_SOURCE:
            begin
                send_idle_pct = 52;
                recv_idle_pct = 30;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // random sequences around the current k and window; the last one may be cut
    // short without its end mark, so it runs on into the next configuration
    task automatic fill_phase(input int budget, input int drain_at);
        int n;
        int len;
        int flavor;
        int j;
        logic [7:0] run_ch;
        logic [7:0] alt_ch;
        logic [7:0] c;
        n = 0;
        while (n < budget)
        begin
            case ($urandom_range(9))
                0:       len = $urandom_range(eff_k(), 1);          // too short for a window
                1:       len = $urandom_range(80, 50);              // counters saturate
                default: len = eff_k() + eff_w() - 2 + $urandom_range(12);
            endcase
            if (len < 1)
                len = 1;
            flavor = $urandom_range(3);
            run_ch = 8'($urandom_range(255));
            alt_ch = 8'($urandom_range(255));
            for (j = 0; j < len && n < budget; j++)
            begin
                case (flavor)
                    0: c = 8'($urandom_range(255));
                    1:
                    begin
                        // nucleotide text
                        case ($urandom_range(3))
                            0:       c = 8'h41;
                            1:       c = 8'h43;
                            2:       c = 8'h47;
                            default: c = 8'h54;
                        endcase
                    end
                    2: c = run_ch;                                 // repeating minimum
                    default: c = j[0] ? alt_ch : run_ch;
                endcase
                queue_char(c, j == len - 1, n == drain_at);
                n++;
            end
        end
    endtask

    task automatic run_phase(input logic [5:0] k, input logic [5:0] w, input pace_t pace,
                             input int drain_at, input bit long_hold);
        wait_drained();
        write_reg(REG_KMER_LENGTH, k);
        write_reg(REG_WINDOW_SIZE, w);
        set_pace(pace);
        fill_phase(PHASE_CHARS, drain_at);
        if (long_hold)
            hold_go = 1'b1;
    endtask

    initial
    begin
        int i;
        set_pace(PACE_SLOW_SINK);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration, sequence shorter than one k-mer: empty end marker
        queue_char(8'h41, 1'b0, 1'b0);
        queue_char(8'h43, 1'b0, 1'b0);
        queue_char(8'h47, 1'b1, 1'b0);
        wait_drained();

        write_reg(REG_KMER_LENGTH, 6'd3);
        write_reg(REG_WINDOW_SIZE, 6'd4);
        // three k-mers, window of four: overall minimum at the end
        queue_char(8'h00, 1'b0, 1'b0);
        queue_char(8'hFF, 1'b0, 1'b0);
        queue_char(8'h41, 1'b0, 1'b0);
        queue_char(8'h43, 1'b0, 1'b0);
        queue_char(8'h54, 1'b1, 1'b0);
        // full windows with byte extremes
        queue_char(8'hFF, 1'b0, 1'b0);
        queue_char(8'hFF, 1'b0, 1'b0);
        queue_char(8'h00, 1'b0, 1'b0);
        queue_char(8'h00, 1'b0, 1'b0);
        queue_char(8'h47, 1'b0, 1'b0);
        queue_char(8'h41, 1'b0, 1'b0);
        queue_char(8'h54, 1'b0, 1'b0);
        queue_char(8'h43, 1'b1, 1'b0);
        // constant run: one minimizer, repeats suppressed, empty end marker
        for (i = 0; i < 10; i++)
            queue_char(8'h41, i == 9, 1'b0);
        // lone character: no k-mer at all
        queue_char(8'h54, 1'b1, 1'b0);

        // random phases; out-of-range values check the clamping
        run_phase(6'd0,  6'd0,  PACE_SLOW_SINK,   -1, 1'b0);
        run_phase(6'd32, 6'd16, PACE_SLOW_SINK,   -1, 1'b0);
        run_phase(6'd63, 6'd31, PACE_SLOW_SINK,   -1, 1'b0);
        run_phase(6'd1,  6'd16, PACE_SLOW_SINK,   -1, 1'b0);
        run_phase(6'd32, 6'd1,  PACE_SLOW_SOURCE, -1, 1'b0);
        run_phase(6'd5,  6'd3,  PACE_SLOW_SOURCE, 20, 1'b0);
        run_phase(6'd15, 6'd10, PACE_SLOW_SOURCE, -1, 1'b0);
        run_phase(6'd2,  6'd4,  PACE_SLOW_SOURCE, -1, 1'b0);
        run_phase(6'd8,  6'd5,  PACE_FULL,        -1, 1'b0);
        run_phase(6'd21, 6'd7,  PACE_FULL,        -1, 1'b0);
        // sink holds off while the source keeps offering: the block backs up
        run_phase(6'd4,  6'd2,  PACE_FULL,        -1, 1'b1);
        run_phase(6'd12, 6'd20, PACE_FULL,        20, 1'b0);

        wait_drained();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
